// ===== hdl/point_table_with_distance_unit_defines.svh =====
// Assertion macros for the point table.
`ifndef POINT_TABLE_WITH_DISTANCE_UNIT_DEFINES_SVH
`define POINT_TABLE_WITH_DISTANCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTD_ASSERT(label, clk, rst_n, prop, msg)
`define PTD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ptd_pkg.sv =====
package ptd_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned FracBits = 8;
  localparam int unsigned IdxW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned CoordW = 20;
  localparam int unsigned WtW = 16;
  localparam int unsigned AreaW = 12;
  localparam int unsigned DistW = 26;
  localparam int unsigned StatW = 3;
  localparam int unsigned SqW = 50;
  localparam int unsigned RootW = 25;
  localparam int unsigned RootSteps = 25;
  localparam logic [CntW-1:0] CountMax = CntW'(TableDepth);

  typedef enum logic [1:0] {
    FuncAppend = 2'd0,
    FuncWrite  = 2'd1,
    FuncQuery  = 2'd2,
    FuncClear  = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    StatOk    = 3'd0,
    StatDup   = 3'd1,
    StatArea  = 3'd2,
    StatFull  = 3'd3,
    StatEmpty = 3'd4
  } status_e;

  localparam logic [0:0] RegAreaWidth = 1'b0;
  localparam logic [0:0] RegAreaHeight = 1'b1;

  typedef struct packed {
    logic [1:0]        func;
    logic [IdxW-1:0]   slot;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [WtW-1:0]    point_weight;
    logic [IdxW-1:0]   first_point;
    logic [IdxW-1:0]   second_point;
    logic              add_weights;
  } in_word_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [DistW-1:0] distance;
    logic [CntW-1:0]  point_count;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [SqW-1:0]  radicand;
  } root_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RootW-1:0] root;
  } root_rsp_t;
endpackage

// ===== hdl/ptd_stream_if.sv =====
interface ptd_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/point_table_with_distance_unit.sv =====
// Point table with distance query. One word is taken at a time. The input is not
// ready while a word is in work or while its result waits in the output register.
// Right after reset the init state writes the depot at the origin into slot 0.
// An insert scans all 64 slots for a duplicate pair, one slot a cycle from the
// coordinate memory, and then presents its result via the check and output states.
// A query reads both points, squares dx and dy on one shared multiplier and then
// runs a 25-step square root, whose result then goes out; when a slot is empty
// the result goes out right after the reads. A clear answers in the next cycle.
`include "point_table_with_distance_unit_defines.svh"
module point_table_with_distance_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [ptd_pkg::AreaW-1:0] cfg_data_i,
  ptd_stream_if.sink                in_if,
  ptd_stream_if.source              out_if
);
  import ptd_pkg::*;

  typedef enum logic [9:0] {
    StInit  = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StScan  = 10'b0000000100,
    StCheck = 10'b0000001000,
    StRdA   = 10'b0000010000,
    StRdB   = 10'b0000100000,
    StMulX  = 10'b0001000000,
    StMulY  = 10'b0010000000,
    StRoot  = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CoordW-1:0] mem_x [TableDepth];
  logic [CoordW-1:0] mem_y [TableDepth];
  logic [WtW-1:0]    mem_w [TableDepth];
  logic [TableDepth-1:0] valid_q, valid_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AreaW-1:0]  area_w_q, area_h_q;

  in_word_t          item_q, item_d;
  logic [IdxW:0]     scan_q, scan_d;
  logic              dup_q, dup_d;
  logic [IdxW-1:0]   rd_addr;
  logic [CoordW-1:0] rd_x_q, rd_y_q;
  logic [WtW-1:0]    rd_w_q;
  logic              rd_v_q;
  logic [CoordW-1:0] ax_q, ay_q, ax_d, ay_d;
  logic [WtW-1:0]    aw_q, aw_d;
  logic [SqW-1:0]    acc_q, acc_d;
  logic [CoordW-1:0] mul_a;
  logic [39:0]       mul_p;
  logic [CoordW-1:0] dx, dy;
  logic              we;
  logic [IdxW-1:0]   wr_addr;
  logic [CoordW-1:0] wr_x, wr_y;
  logic [WtW-1:0]    wr_w;
  out_word_t         out_q, out_d;
  logic              out_v_q, out_v_d;
  root_req_t         rreq;
  root_rsp_t         rrsp;
  logic              root_start;
  logic [DistW-1:0]  wsum;
  logic [IdxW-1:0]   ins_idx;
  logic              ins_ok;

  assign in_if.ready = (state_q == StIdle) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;

  assign dx = (rd_x_q > ax_q) ? rd_x_q - ax_q : ax_q - rd_x_q;
  assign dy = (rd_y_q > ay_q) ? rd_y_q - ay_q : ay_q - rd_y_q;
  assign mul_a = (state_q == StMulX) ? dx : dy;
  assign mul_p = mul_a * mul_a;
  assign wsum = DistW'(aw_q >> 1) + DistW'(rd_w_q >> 1);

  assign ins_idx = (item_q.func == FuncAppend) ? count_q[IdxW-1:0] : item_q.slot;
  assign ins_ok = (item_q.func == FuncWrite) || (count_q < CntW'(TableDepth));

  always_comb begin
    case (state_q)
      StScan:  rd_addr = scan_q[IdxW-1:0];
      StRdA:   rd_addr = item_q.first_point;
      default: rd_addr = item_q.second_point;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_w[wr_addr] <= wr_w;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
    rd_w_q <= mem_w[rd_addr];
    rd_v_q <= valid_q[rd_addr];
  end

  assign rreq.radicand = acc_q;
  assign rreq.start = root_start;
  ptd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rreq),
    .rsp_o  (rrsp)
  );

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    scan_d = scan_q;
    dup_d = dup_q;
    valid_d = valid_q;
    count_d = count_q;
    ax_d = ax_q;
    ay_d = ay_q;
    aw_d = aw_q;
    acc_d = acc_q;
    out_d = out_q;
    out_v_d = out_v_q;
    we = 1'b0;
    wr_addr = ins_idx;
    wr_x = item_q.coord_x;
    wr_y = item_q.coord_y;
    wr_w = item_q.point_weight;
    root_start = 1'b0;
    if (out_if.ready) begin
      out_v_d = 1'b0;
    end
    case (state_q)
      StInit: begin
        we = 1'b1;
        wr_addr = '0;
        wr_x = '0;
        wr_y = '0;
        wr_w = '0;
        state_d = StIdle;
      end
      StIdle: begin
        if (in_if.valid && in_if.ready) begin
          item_d = in_if.data;
          scan_d = '0;
          dup_d = 1'b0;
          case (func_e'(in_if.data.func))
            FuncQuery: state_d = StRdA;
            FuncClear: begin
              valid_d = '0;
              count_d = '0;
              out_d = '{status: StatOk, distance: '0, point_count: '0};
              out_v_d = 1'b1;
            end
            default: state_d = StScan;
          endcase
        end
      end
      StScan: begin
        if (scan_q != '0 && rd_v_q && rd_x_q == item_q.coord_x
            && rd_y_q == item_q.coord_y) begin
          dup_d = 1'b1;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == (IdxW+1)'(TableDepth)) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        out_d.distance = '0;
        state_d = StOut;
        if (dup_q) begin
          out_d.status = StatDup;
        end else if ({1'b0, item_q.coord_x} > {1'b0, area_w_q, FracBits'(0)}
                     || {1'b0, item_q.coord_y} > {1'b0, area_h_q, FracBits'(0)}) begin
          out_d.status = StatArea;
        end else if (!ins_ok) begin
          out_d.status = StatFull;
        end else begin
          out_d.status = StatOk;
          we = 1'b1;
          valid_d[ins_idx] = 1'b1;
          if (count_q < CountMax) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      StRdA: state_d = StRdB;
      StRdB: begin
        ax_d = rd_x_q;
        ay_d = rd_y_q;
        aw_d = rd_w_q;
        if (!rd_v_q || !valid_q[item_q.second_point]) begin
          out_d.status = StatEmpty;
          out_d.distance = '0;
          state_d = StOut;
        end else begin
          state_d = StMulX;
        end
      end
      StMulX: begin
        acc_d = SqW'(mul_p);
        state_d = StMulY;
      end
      StMulY: begin
        acc_d = SqW'(225) * (acc_q + SqW'(mul_p));
        state_d = StRoot;
      end
      StRoot: begin
        if (!rrsp.busy && !rrsp.done && acc_q != '1) begin
          root_start = 1'b1;
          acc_d = '1;
        end
        if (rrsp.done) begin
          out_d.status = StatOk;
          out_d.distance = DistW'(rrsp.root)
                           + (item_q.add_weights ? wsum : DistW'(0));
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_v_q) begin
          out_d.point_count = count_q;
          out_v_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      valid_q <= TableDepth'(1);
      count_q <= CntW'(1);
      out_v_q <= 1'b0;
      area_w_q <= '1;
      area_h_q <= '1;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
      if (cfg_we_i && cfg_index_i == RegAreaWidth) area_w_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == RegAreaHeight) area_h_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    scan_q <= scan_d;
    dup_q <= dup_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    aw_q <= aw_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  `PTD_ASSERT(a_ready_idle, clk_i, rst_ni, in_if.ready |-> state_q == StIdle, "ready outside idle")
  `PTD_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CountMax, "count overflow")
  `PTD_ASSERT(a_root_done, clk_i, rst_ni, rrsp.done |-> state_q == StRoot, "stray root result")
  `PTD_ASSERT(a_accept_busy, clk_i, rst_ni, (in_if.valid && in_if.ready) |=> !in_if.ready, "accepted twice")
endmodule

// ===== hdl/ptd_sqrt.sv =====
module ptd_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptd_pkg::root_req_t  req_i,
  output ptd_pkg::root_rsp_t  rsp_o
);
  import ptd_pkg::*;

  logic [SqW-1:0]         rem_q, rem_d;
  logic [SqW-1:0]         res_q, res_d;
  logic [SqW-1:0]         bit_q, bit_d;
  logic [$clog2(RootSteps+1)-1:0] cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;
  logic [SqW-1:0]         trial;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.radicand;
      res_d = '0;
      bit_d = SqW'(1) << (SqW - 2);
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(RootSteps+1))'(RootSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];
endmodule
